@@ rtl/frps_pkg.sv @@
// package for the fixed radius point search block
// holds request and result structs, opcodes and size constants; no dependencies
package frps_pkg;

  localparam int MaxPointsDef = 64;
  localparam int CoordBitsDef = 32;
  localparam int IdxW = 6;
  localparam int CoordW = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FIND   = 2'd2,
    OP_ANY    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [CoordW-1:0]        search_radius;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic [IdxW-1:0]          point_index;
    logic signed [CoordW-1:0] match_x;
    logic signed [CoordW-1:0] match_y;
    logic signed [CoordW-1:0] match_z;
    logic                     last;
  } res_t;

  // what one cell hands to the next along the row
  typedef struct packed {
    logic                     vld;
    logic                     qend;
    logic [IdxW-1:0]          idx;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
  } tok_t;

endpackage

@@ rtl/frps_cell.sv @@
// one distance cell: squares one coordinate difference and adds to the running sum
// depends on frps_pkg
module frps_cell #(
  parameter int CoordBits = frps_pkg::CoordBitsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  frps_pkg::tok_t            tok_in,
  input  logic [65:0]               sum_in,
  input  logic signed [CoordBits:0] a_in,
  input  logic signed [CoordBits:0] b_in,
  output frps_pkg::tok_t            tok_out,
  output logic [65:0]               sum_out
);

  logic [CoordBits:0]   mag;
  logic signed [CoordBits+1:0] d;
  logic [2*CoordBits+1:0] sq;
  frps_pkg::tok_t tok_r;
  logic [65:0]    sum_r;

  always_comb begin
    d   = {a_in[CoordBits], a_in} - {b_in[CoordBits], b_in};
    mag = d[CoordBits+1] ? (CoordBits+1)'(0) - d[CoordBits:0] : d[CoordBits:0];
    sq  = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld  <= 1'b0;
      tok_r.qend <= 1'b0;
    end else begin
      tok_r.vld  <= tok_in.vld;
      tok_r.qend <= tok_in.qend;
    end
    tok_r.idx <= tok_in.idx;
    tok_r.px  <= tok_in.px;
    tok_r.py  <= tok_in.py;
    tok_r.pz  <= tok_in.pz;
    sum_r     <= sum_in + 66'(sq);
  end

  assign tok_out = tok_r;
  assign sum_out = sum_r;

endmodule

@@ rtl/fixed_radius_point_search.sv @@
// fixed radius point search top level: point memory, three-cell distance row, result logic
// a clear or append is accepted when start is seen while idle and gives no result; a query
// holds busy until its final result, which shows in the cycle busy drops
// a new request is taken only while busy is low; a query walks memory with one read per cycle
// results stream at most one per cycle on out_valid, the receiver cannot stall
// reset (rst_n, synchronous) empties the list; memory contents are not cleared
// depends on frps_pkg and frps_cell
module fixed_radius_point_search #(
  parameter int MaxPoints = frps_pkg::MaxPointsDef,
  parameter int CoordBits = frps_pkg::CoordBitsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  frps_pkg::req_t in_req,
  output logic           out_valid,
  output frps_pkg::res_t out_res
);

  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int CB = CoordBits;

  typedef enum logic [1:0] { ST_IDLE, ST_WALK, ST_DRAIN } state_t;

  logic [3*CB-1:0] mem [MaxPoints];
  state_t state_r;
  logic [CW-1:0] count_r, rd_r;
  logic hit_r, op_any_r;
  logic signed [CB:0] ox_r, oy_r, oz_r;
  logic [63:0] r2_r;
  logic [CoordBits-1:0] rq_x, rq_y, rq_z;
  logic [3*CB-1:0] rd_data_r;
  frps_pkg::tok_t tok0, tok1, tok2, tok3;
  logic rd_vld_r, rd_qend_r;
  logic [frps_pkg::IdxW-1:0] rd_idx_r;
  logic [65:0] s1, s2, s3;
  logic accept, issue, match;
  logic pend_r;
  frps_pkg::res_t pend_res_r, res_nxt;
  logic out_valid_r;
  frps_pkg::res_t out_res_r;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign rq_x = in_req.coord_x[CB-1:0];
  assign rq_y = in_req.coord_y[CB-1:0];
  assign rq_z = in_req.coord_z[CB-1:0];
  assign issue = (state_r == ST_WALK) && (rd_r < count_r);

  always_ff @(posedge clk) begin
    if (accept && in_req.opcode == frps_pkg::OP_APPEND && count_r < CW'(MaxPoints))
      mem[count_r[AW-1:0]] <= {rq_x, rq_y, rq_z};
    rd_data_r <= mem[rd_r[AW-1:0]];
  end

  // token for the row is built from registered memory data
  always_comb begin
    tok0.vld  = rd_vld_r;
    tok0.qend = rd_qend_r;
    tok0.idx  = rd_idx_r;
    tok0.px   = frps_pkg::CoordW'($signed(rd_data_r[3*CB-1:2*CB]));
    tok0.py   = frps_pkg::CoordW'($signed(rd_data_r[2*CB-1:CB]));
    tok0.pz   = frps_pkg::CoordW'($signed(rd_data_r[CB-1:0]));
  end

  frps_cell #(.CoordBits(CB)) u_cx (.clk, .rst_n, .tok_in(tok0), .sum_in(66'd0),
    .a_in($signed({rd_data_r[3*CB-1], rd_data_r[3*CB-1:2*CB]})), .b_in(ox_r),
    .tok_out(tok1), .sum_out(s1));
  frps_cell #(.CoordBits(CB)) u_cy (.clk, .rst_n, .tok_in(tok1), .sum_in(s1),
    .a_in($signed({tok1.py[CB-1], tok1.py[CB-1:0]})), .b_in(oy_r),
    .tok_out(tok2), .sum_out(s2));
  frps_cell #(.CoordBits(CB)) u_cz (.clk, .rst_n, .tok_in(tok2), .sum_in(s2),
    .a_in($signed({tok2.pz[CB-1], tok2.pz[CB-1:0]})), .b_in(oz_r),
    .tok_out(tok3), .sum_out(s3));

  assign match = tok3.vld && (s3[65:64] == 2'b00) && (s3[63:0] <= r2_r);

  always_comb begin
    res_nxt = '0;
    res_nxt.found = 1'b1;
    res_nxt.point_index = tok3.idx;
    res_nxt.match_x = tok3.px;
    res_nxt.match_y = tok3.py;
    res_nxt.match_z = tok3.pz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_r        <= '0;
      rd_vld_r    <= 1'b0;
      rd_qend_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      op_any_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= issue;
      rd_qend_r   <= (state_r == ST_WALK) && !issue;
      rd_idx_r    <= frps_pkg::IdxW'(rd_r);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (frps_pkg::op_t'(in_req.opcode))
              frps_pkg::OP_CLEAR: count_r <= '0;
              frps_pkg::OP_APPEND: if (count_r < CW'(MaxPoints)) count_r <= count_r + 1'b1;
              frps_pkg::OP_FIND, frps_pkg::OP_ANY: begin
                state_r  <= ST_WALK;
                rd_r     <= '0;
                hit_r    <= 1'b0;
                pend_r   <= 1'b0;
                op_any_r <= (in_req.opcode == frps_pkg::OP_ANY);
                ox_r <= $signed({rq_x[CB-1], rq_x});
                oy_r <= $signed({rq_y[CB-1], rq_y});
                oz_r <= $signed({rq_z[CB-1], rq_z});
                r2_r <= 64'(in_req.search_radius) * 64'(in_req.search_radius);
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (issue) rd_r <= rd_r + 1'b1;
          else state_r <= ST_DRAIN;
        end
        ST_DRAIN: ;
        default: state_r <= ST_IDLE;
      endcase
      // result side: for a find, hold one match back so the final one can carry last; an any query only records a hit
      if (state_r != ST_IDLE) begin
        if (match) begin
          hit_r <= 1'b1;
          if (!op_any_r) begin
            pend_r     <= 1'b1;
            pend_res_r <= res_nxt;
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_res_r   <= pend_res_r;
            end
          end
        end
        if (tok3.qend) begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          out_res_r   <= '0;
          out_res_r.last <= 1'b1;
          if (op_any_r) out_res_r.found <= hit_r;
          else if (pend_r) begin
            out_res_r      <= pend_res_r;
            out_res_r.last <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MaxPoints)) else $error("point count beyond capacity");
  a_busy_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> $stable(count_r)) else $error("list changed during query");
  a_qend_valid: assert property (@(posedge clk) disable iff (!rst_n)
    tok3.qend |=> out_valid && out_res.last) else $error("query ended without last result");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last |-> !busy) else $error("still busy after last result");

endmodule
